>>> sv/ppp_pkg.sv
`timescale 1ns / 1ps
// shared widths, stage numbering, register codes and helpers for the
// pinhole point projection core; no dependencies
package ppp_pkg;

  localparam int unsigned QW      = 16;  // quaternion component
  localparam int unsigned PW      = 32;  // point, translation, pixel
  localparam int unsigned EW      = 35;  // unclamped rotation entry
  localparam int unsigned RW      = 31;  // clamped rotation entry, +-2^29
  localparam int unsigned PRODW   = RW + PW;
  localparam int unsigned CAMW    = 64;
  localparam int unsigned MAGW    = 62;  // |camera coordinate| < 2^62
  localparam int unsigned PPW     = 63;  // 31 x 32 partial product
  localparam int unsigned NUMW    = 94;  // |num| * focal
  localparam int unsigned QBITS   = 34;  // quotient bits kept before clipping
  localparam int unsigned DIV_STG = 3 + QBITS + 1;

  localparam int unsigned ROT_STG = 4;
  localparam int unsigned STG_MAG = ROT_STG;
  localparam int unsigned STG_DIV = STG_MAG + 1;
  localparam int unsigned NSTG    = STG_DIV + DIV_STG;

  localparam logic [31:0] FOCAL_RST = 32'h0001_0000;
  localparam logic signed [EW-1:0] ONE_Q28 = 35'sd268435456;
  localparam logic signed [EW-1:0] RCLAMP  = 35'sd536870912;

  localparam int unsigned AW = 4;

  typedef enum logic [1:0] {
    REG_FOCAL,
    REG_PRIN_X,
    REG_PRIN_Y
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] focal;
    logic [31:0] cx;
    logic [31:0] cy;
  } cfg_t;

  function automatic logic signed [RW-1:0] clamp_r(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    begin
      if (v > RCLAMP) c = RCLAMP;
      else if (v < -RCLAMP) c = -RCLAMP;
      else c = v;
      return RW'(c);
    end
  endfunction

endpackage

>>> sv/ppp_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the projection core items
// depends on nothing; widths follow the item fields
interface ppp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, point_x, point_y, point_z, quat_w, quat_x, quat_y,
                  quat_z, trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, quat_w, quat_x, quat_y,
                quat_z, trans_x, trans_y, trans_z, output ready);
endinterface

interface ppp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               depth_zero;
  logic               saturated;

  modport source (output valid, pixel_u, pixel_v, depth_zero, saturated, input ready);
  modport sink (input valid, pixel_u, pixel_v, depth_zero, saturated, output ready);
endinterface

>>> sv/ppp_rotate.sv
`timescale 1ns / 1ps
// quaternion to rotation matrix, rotate and translate: four register stages
// depends on ppp_pkg
module ppp_rotate
  import ppp_pkg::*;
(
  input  logic                   clk_i,
  input  logic [ROT_STG-1:0]     en_i,
  input  logic signed [PW-1:0]   point_x_i,
  input  logic signed [PW-1:0]   point_y_i,
  input  logic signed [PW-1:0]   point_z_i,
  input  logic signed [QW-1:0]   quat_w_i,
  input  logic signed [QW-1:0]   quat_x_i,
  input  logic signed [QW-1:0]   quat_y_i,
  input  logic signed [QW-1:0]   quat_z_i,
  input  logic signed [PW-1:0]   trans_x_i,
  input  logic signed [PW-1:0]   trans_y_i,
  input  logic signed [PW-1:0]   trans_z_i,
  output logic signed [CAMW-1:0] cam_x_o,
  output logic signed [CAMW-1:0] cam_y_o,
  output logic signed [CAMW-1:0] cam_z_o
);

  // stage 0: quaternion products
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  logic signed [PW-1:0] p0_q [3];
  logic signed [PW-1:0] t0_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zw_q <= quat_z_i * quat_w_i;
      xz_q <= quat_x_i * quat_z_i;
      yw_q <= quat_y_i * quat_w_i;
      yz_q <= quat_y_i * quat_z_i;
      xw_q <= quat_x_i * quat_w_i;
      p0_q[0] <= point_x_i;
      p0_q[1] <= point_y_i;
      p0_q[2] <= point_z_i;
      t0_q[0] <= trans_x_i;
      t0_q[1] <= trans_y_i;
      t0_q[2] <= trans_z_i;
    end
  end

  // stage 1: matrix entries, clamped to +-2.0
  logic signed [EW-1:0] e_d [9];
  logic signed [RW-1:0] r_q [9];
  logic signed [PW-1:0] p1_q [3];
  logic signed [PW-1:0] t1_q [3];

  always_comb begin
    e_d[0] = ONE_Q28 - ((EW'(yy_q) + EW'(zz_q)) <<< 1);
    e_d[1] = (EW'(xy_q) - EW'(zw_q)) <<< 1;
    e_d[2] = (EW'(xz_q) + EW'(yw_q)) <<< 1;
    e_d[3] = (EW'(xy_q) + EW'(zw_q)) <<< 1;
    e_d[4] = ONE_Q28 - ((EW'(xx_q) + EW'(zz_q)) <<< 1);
    e_d[5] = (EW'(yz_q) - EW'(xw_q)) <<< 1;
    e_d[6] = (EW'(xz_q) - EW'(yw_q)) <<< 1;
    e_d[7] = (EW'(yz_q) + EW'(xw_q)) <<< 1;
    e_d[8] = ONE_Q28 - ((EW'(xx_q) + EW'(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 9; i++) r_q[i] <= clamp_r(e_d[i]);
      p1_q <= p0_q;
      t1_q <= t0_q;
    end
  end

  // stage 2: nine entry by coordinate products
  logic signed [PRODW-1:0] pr_q [9];
  logic signed [PW-1:0]    t2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[i*3+j] <= PRODW'(r_q[i*3+j]) * PRODW'(p1_q[j]);
        end
      end
      t2_q <= t1_q;
    end
  end

  // stage 3: row sums plus translation in Q.44
  logic signed [CAMW-1:0] cam_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int i = 0; i < 3; i++) begin
        cam_q[i] <= CAMW'(pr_q[i*3]) + CAMW'(pr_q[i*3+1]) + CAMW'(pr_q[i*3+2])
                    + (CAMW'(t2_q[i]) <<< 28);
      end
    end
  end

  assign cam_x_o = cam_q[0];
  assign cam_y_o = cam_q[1];
  assign cam_z_o = cam_q[2];

endmodule

>>> sv/ppp_divide.sv
`timescale 1ns / 1ps
// scaled division pipeline: |num| * focal / |den|, one quotient bit a stage,
// rounding, sign, principal offset and 32-bit clipping; depends on ppp_pkg
module ppp_divide
  import ppp_pkg::*;
(
  input  logic                 clk_i,
  input  logic [DIV_STG-1:0]   en_i,
  input  logic [MAGW-1:0]      num_i,
  input  logic [MAGW-1:0]      den_i,
  input  logic                 neg_i,
  input  logic [31:0]          focal_i,
  input  logic [31:0]          ofs_i,
  output logic signed [PW-1:0] pix_o,
  output logic                 sat_o
);

  localparam int unsigned LAST = DIV_STG - 1;
  localparam int unsigned HALF = MAGW / 2;

  logic [MAGW-1:0] den_q [LAST];
  logic            neg_q [LAST];
  logic            ovf_q [2:LAST-1];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
    for (int s = 1; s < LAST; s++) begin
      if (en_i[s]) begin
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
    for (int s = 3; s < LAST; s++) begin
      if (en_i[s]) ovf_q[s] <= ovf_q[s-1];
    end
  end

  // two partial products, then the full dividend
  logic [PPW-1:0]  lo_q, hi_q;
  logic [NUMW-1:0] n_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lo_q <= PPW'(num_i[HALF-1:0]) * PPW'(focal_i);
      hi_q <= PPW'(num_i[MAGW-1:HALF]) * PPW'(focal_i);
    end
    if (en_i[1]) n_q <= {hi_q, HALF'(0)} + NUMW'(lo_q);
  end

  // quotient clips when the top bits alone already reach the divisor
  logic [MAGW-1:0]  rem_q [QBITS+1];
  logic [QBITS-1:0] low_q [QBITS];
  logic [QBITS-1:0] quo_q [QBITS+1];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ovf_q[2] <= MAGW'(n_q[NUMW-1:QBITS]) >= den_q[1];
      rem_q[0] <= MAGW'(n_q[NUMW-1:QBITS]);
      low_q[0] <= n_q[QBITS-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar g = 1; g <= QBITS; g++) begin : g_step
    logic [MAGW:0] trial;
    logic          ge;
    assign trial = {rem_q[g-1], low_q[g-1][QBITS-1]};
    assign ge    = trial >= {1'b0, den_q[g+1]};
    always_ff @(posedge clk_i) begin
      if (en_i[g+2]) begin
        rem_q[g] <= ge ? MAGW'(trial - {1'b0, den_q[g+1]}) : MAGW'(trial);
        quo_q[g] <= {quo_q[g-1][QBITS-2:0], ge};
      end
    end
    if (g < QBITS) begin : g_low
      always_ff @(posedge clk_i) begin
        if (en_i[g+2]) low_q[g] <= low_q[g-1] << 1;
      end
    end
  end

  // round to nearest, ties away from zero, then offset and clip
  logic                 rnd;
  logic [QBITS:0]       qr;
  logic                 big;
  logic signed [PW+4:0] qs, sum;
  logic signed [PW-1:0] pix_d;
  logic                 sat_d;

  always_comb begin
    rnd = {rem_q[QBITS], 1'b0} >= {1'b0, den_q[LAST-1]};
    qr  = (QBITS+1)'(quo_q[QBITS]) + (QBITS+1)'(rnd);
    big = ovf_q[LAST-1] | qr[QBITS] | qr[QBITS-1];
    qs  = $signed({2'b00, qr});
    sum = (neg_q[LAST-1] ? -qs : qs) + (PW+5)'($signed(ofs_i));
    if (big) begin
      sat_d = 1'b1;
      pix_d = neg_q[LAST-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else if (sum > (PW+5)'(32'sh7FFF_FFFF)) begin
      sat_d = 1'b1;
      pix_d = {1'b0, {(PW-1){1'b1}}};
    end else if (sum < -(PW+5)'(33'sh0_8000_0000)) begin
      sat_d = 1'b1;
      pix_d = {1'b1, {(PW-1){1'b0}}};
    end else begin
      sat_d = 1'b0;
      pix_d = PW'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LAST]) begin
      pix_o <= pix_d;
      sat_o <= sat_d;
    end
  end

endmodule

>>> sv/ppp_cfg.sv
`timescale 1ns / 1ps
// apb register file: focal length and principal point
// depends on ppp_pkg
module ppp_cfg
  import ppp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cfg_t          cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[AW-1:2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_FOCAL:  cfg_d.focal = pwdata;
        REG_PRIN_X: cfg_d.cx    = pwdata;
        REG_PRIN_Y: cfg_d.cy    = pwdata;
        default:    cfg_d       = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FOCAL:  prdata = cfg_q.focal;
      REG_PRIN_X: prdata = cfg_q.cx;
      REG_PRIN_Y: prdata = cfg_q.cy;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{focal: FOCAL_RST, cx: '0, cy: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/pinhole_point_projection_core.sv
`timescale 1ns / 1ps
// an accepted item moves through the rotation, magnitude and divider stages in turn to out_o
// throughput: one item per cycle; each stage holds under backpressure and
// takes a new item as soon as its content moves on
// the depth comes from the bit-per-stage divider (34 quotient bits)
// reset clears all stage valid bits and the registers to focal 1.0, center 0
module pinhole_point_projection_core
  import ppp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ppp_in_if.sink        in_i,
  ppp_out_if.source     out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t cfg;

  ppp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // per-stage valid bits and load enables
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  assign en[NSTG] = out_o.ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready = en[0];

  logic signed [CAMW-1:0] cam_x, cam_y, cam_z;

  ppp_rotate u_rotate (
    .clk_i     (clk_i),
    .en_i      (en[ROT_STG-1:0]),
    .point_x_i (in_i.point_x),
    .point_y_i (in_i.point_y),
    .point_z_i (in_i.point_z),
    .quat_w_i  (in_i.quat_w),
    .quat_x_i  (in_i.quat_x),
    .quat_y_i  (in_i.quat_y),
    .quat_z_i  (in_i.quat_z),
    .trans_x_i (in_i.trans_x),
    .trans_y_i (in_i.trans_y),
    .trans_z_i (in_i.trans_z),
    .cam_x_o   (cam_x),
    .cam_y_o   (cam_y),
    .cam_z_o   (cam_z)
  );

  // magnitudes and signs for the dividers
  logic [CAMW-1:0] abs_x, abs_y, abs_z;
  logic [MAGW-1:0] mag_x_q, mag_y_q, mag_z_q;
  logic            neg_x_q, neg_y_q;
  logic            zero_q [STG_MAG:NSTG-1];

  assign abs_x = cam_x[CAMW-1] ? CAMW'(-cam_x) : CAMW'(cam_x);
  assign abs_y = cam_y[CAMW-1] ? CAMW'(-cam_y) : CAMW'(cam_y);
  assign abs_z = cam_z[CAMW-1] ? CAMW'(-cam_z) : CAMW'(cam_z);

  always_ff @(posedge clk_i) begin
    if (en[STG_MAG]) begin
      mag_x_q         <= abs_x[MAGW-1:0];
      mag_y_q         <= abs_y[MAGW-1:0];
      mag_z_q         <= abs_z[MAGW-1:0];
      neg_x_q         <= cam_x[CAMW-1] ^ cam_z[CAMW-1];
      neg_y_q         <= cam_y[CAMW-1] ^ cam_z[CAMW-1];
      zero_q[STG_MAG] <= (cam_z == '0);
    end
    for (int k = STG_MAG + 1; k < NSTG; k++) begin
      if (en[k]) zero_q[k] <= zero_q[k-1];
    end
  end

  logic signed [PW-1:0] pix_u, pix_v;
  logic                 sat_u, sat_v;

  ppp_divide u_div_u (
    .clk_i   (clk_i),
    .en_i    (en[NSTG-1:STG_DIV]),
    .num_i   (mag_x_q),
    .den_i   (mag_z_q),
    .neg_i   (neg_x_q),
    .focal_i (cfg.focal),
    .ofs_i   (cfg.cx),
    .pix_o   (pix_u),
    .sat_o   (sat_u)
  );

  ppp_divide u_div_v (
    .clk_i   (clk_i),
    .en_i    (en[NSTG-1:STG_DIV]),
    .num_i   (mag_y_q),
    .den_i   (mag_z_q),
    .neg_i   (neg_y_q),
    .focal_i (cfg.focal),
    .ofs_i   (cfg.cy),
    .pix_o   (pix_v),
    .sat_o   (sat_v)
  );

  // zero depth forces zero pixels and no clip flag
  assign out_o.valid      = v_q[NSTG-1];
  assign out_o.depth_zero = zero_q[NSTG-1];
  assign out_o.pixel_u    = zero_q[NSTG-1] ? '0 : pix_u;
  assign out_o.pixel_v    = zero_q[NSTG-1] ? '0 : pix_v;
  assign out_o.saturated  = !zero_q[NSTG-1] && (sat_u || sat_v);

endmodule

>>> sv/ppp_chk.sv
`timescale 1ns / 1ps
// port-level checks for the projection core, bound to the top level
// depends on the top level's channel ports only
module ppp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_u,
  input logic [31:0] pixel_v,
  input logic        depth_zero,
  input logic        saturated
);

  // a free output slot lets the whole pipe move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side free");

  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && depth_zero) |-> (pixel_u == 32'h0 && pixel_v == 32'h0 && !saturated))
    else $error("zero depth item with nonzero pixels or clip flag");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && saturated) |->
      (pixel_u == 32'h7FFF_FFFF || pixel_u == 32'h8000_0000 ||
       pixel_v == 32'h7FFF_FFFF || pixel_v == 32'h8000_0000))
    else $error("clip flag without a pixel on a rail");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_u) && $stable(pixel_v)))
    else $error("stalled result changed");

endmodule

bind pinhole_point_projection_core ppp_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .pixel_u    (out_o.pixel_u),
  .pixel_v    (out_o.pixel_v),
  .depth_zero (out_o.depth_zero),
  .saturated  (out_o.saturated)
);

>>> tb/pinhole_point_projection_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for the pinhole point projection core: random and edge points
// under several camera settings and handshake idle patterns
// depends on ppp_pkg, ppp_if and pinhole_point_projection_core
module pinhole_point_projection_core_test
  import ppp_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned RAND_PER_PHASE = 165;
  localparam logic [AW-1:0] ADDR_UNMAPPED = 4'hC;
  localparam longint ONE_Q28_L = 64'sd268435456;
  localparam longint R_LIMIT   = 64'sd536870912;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] tx, ty, tz;
  } point_item_t;

  typedef struct packed {
    logic signed [31:0] u, v;
    logic               zero_depth;
    logic               clipped;
  } pixel_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ppp_in_if  in_ch();
  ppp_out_if out_ch();

  pinhole_point_projection_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // camera settings as the block holds them
  logic [31:0]        focal_cfg = FOCAL_RST;
  logic signed [31:0] cx_cfg = '0;
  logic signed [31:0] cy_cfg = '0;

  point_item_t points_pending[$];
  pixel_item_t pixels_expected[$];
  point_item_t point_on_bus;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clip_entry(longint e);
    if (e > R_LIMIT) return R_LIMIT;
    if (e < -R_LIMIT) return -R_LIMIT;
    return e;
  endfunction

  // offset = round(|num| * f / |den|) with sign, plus center, saturated
  function automatic logic signed [31:0] pixel_coord(longint num, longint den,
                                                     longint center, inout bit clip);
    logic [127:0] prod, quo, rem, num_mag, den_mag;
    longint q, coord;
    num_mag = num < 0 ? 128'(-num) : 128'(num);
    den_mag = den < 0 ? 128'(-den) : 128'(den);
    prod = num_mag * {96'b0, focal_cfg};
    quo = prod / den_mag;
    rem = prod % den_mag;
    if (quo >= (128'(1) << 50)) q = longint'(1) << 50;
    else begin
      q = longint'(quo[63:0]);
      if ((rem << 1) >= den_mag) q++;
    end
    if (q > (longint'(1) << 40)) q = longint'(1) << 40;
    coord = (((num < 0) != (den < 0)) ? -q : q) + center;
    if (coord > 64'sd2147483647) begin
      coord = 64'sd2147483647;
      clip = 1'b1;
    end
    if (coord < -64'sd2147483648) begin
      coord = -64'sd2147483648;
      clip = 1'b1;
    end
    return coord[31:0];
  endfunction

  function automatic pixel_item_t project_point(point_item_t it);
    longint w, x, y, z;
    longint rot[3][3];
    longint p[3], t[3], cam[3];
    pixel_item_t res;
    bit clip;
    clip = 1'b0;
    w = it.qw; x = it.qx; y = it.qy; z = it.qz;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    t[0] = it.tx; t[1] = it.ty; t[2] = it.tz;
    rot[0][0] = clip_entry(ONE_Q28_L - 2 * (y * y + z * z));
    rot[0][1] = clip_entry(2 * (x * y - z * w));
    rot[0][2] = clip_entry(2 * (x * z + y * w));
    rot[1][0] = clip_entry(2 * (x * y + z * w));
    rot[1][1] = clip_entry(ONE_Q28_L - 2 * (x * x + z * z));
    rot[1][2] = clip_entry(2 * (y * z - x * w));
    rot[2][0] = clip_entry(2 * (x * z - y * w));
    rot[2][1] = clip_entry(2 * (y * z + x * w));
    rot[2][2] = clip_entry(ONE_Q28_L - 2 * (x * x + y * y));
    for (int i = 0; i < 3; i++)
      cam[i] = rot[i][0] * p[0] + rot[i][1] * p[1] + rot[i][2] * p[2] + t[i] * ONE_Q28_L;
    if (cam[2] == 0) begin
      res = '{u: '0, v: '0, zero_depth: 1'b1, clipped: 1'b0};
      return res;
    end
    res.u = pixel_coord(cam[0], cam[2], longint'(cx_cfg), clip);
    res.v = pixel_coord(cam[1], cam[2], longint'(cy_cfg), clip);
    res.zero_depth = 1'b0;
    res.clipped = clip;
    return res;
  endfunction

  function automatic point_item_t make_point(int px, int py, int pz, shortint qw,
                                             shortint qx, shortint qy, shortint qz,
                                             int tx, int ty, int tz);
    point_item_t it;
    it = '{px: px, py: py, pz: pz, qw: qw, qx: qx, qy: qy, qz: qz,
           tx: tx, ty: ty, tz: tz};
    return it;
  endfunction

  function automatic int rand_q16(int unsigned span_units);
    return int'($urandom_range(2 * span_units * 65536)) - int'(span_units * 65536);
  endfunction

  function automatic point_item_t rand_point();
    point_item_t it;
    real a[4];
    real norm;
    int unsigned mode;
    mode = $urandom_range(99);
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom};
    if (mode >= 15) begin
      // realistic scene: unit rotation, camera translation with positive depth
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
        a[i] = real'(int'($urandom_range(2000)) - 1000);
        norm += a[i] * a[i];
      end
      if (norm == 0.0) begin
        a[0] = 1.0;
        norm = 1.0;
      end
      norm = $sqrt(norm);
      it.qw = 16'($rtoi(a[0] / norm * 16384.0));
      it.qx = 16'($rtoi(a[1] / norm * 16384.0));
      it.qy = 16'($rtoi(a[2] / norm * 16384.0));
      it.qz = 16'($rtoi(a[3] / norm * 16384.0));
      it.px = rand_q16(100);
      it.py = rand_q16(100);
      it.pz = rand_q16(100);
      it.tx = rand_q16(50);
      it.ty = rand_q16(50);
      it.tz = int'($urandom_range(300 * 65536)) + 65536;
      if (mode < 30) begin
        // identity pose with depth cancelled exactly
        it.qw = 16'sd16384; it.qx = '0; it.qy = '0; it.qz = '0;
        it.tz = -it.pz;
      end else if (mode < 38) begin
        // tiny depth pushes pixels out of range
        it.qw = 16'sd16384; it.qx = '0; it.qy = '0; it.qz = '0;
        it.tz = -it.pz + int'($urandom_range(4)) - 2;
      end
    end
    return it;
  endfunction

  task automatic write_reg(logic [AW-1:0] addr, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      AW'(REG_FOCAL) << 2: focal_cfg = value;
      AW'(REG_PRIN_X) << 2: cx_cfg = value;
      AW'(REG_PRIN_Y) << 2: cy_cfg = value;
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [31:0] f, logic [31:0] cx, logic [31:0] cy);
    write_reg(AW'(REG_FOCAL) << 2, f);
    write_reg(AW'(REG_PRIN_X) << 2, cx);
    write_reg(AW'(REG_PRIN_Y) << 2, cy);
  endtask

  task automatic wait_drained();
    while (points_pending.size() != 0 || in_ch.valid || pixels_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // sender side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.point_x <= '0; in_ch.point_y <= '0; in_ch.point_z <= '0;
      in_ch.quat_w <= '0; in_ch.quat_x <= '0; in_ch.quat_y <= '0; in_ch.quat_z <= '0;
      in_ch.trans_x <= '0; in_ch.trans_y <= '0; in_ch.trans_z <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        pixels_expected.push_back(project_point(point_on_bus));
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (points_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          point_on_bus = points_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.point_x <= point_on_bus.px;
          in_ch.point_y <= point_on_bus.py;
          in_ch.point_z <= point_on_bus.pz;
          in_ch.quat_w <= point_on_bus.qw;
          in_ch.quat_x <= point_on_bus.qx;
          in_ch.quat_y <= point_on_bus.qy;
          in_ch.quat_z <= point_on_bus.qz;
          in_ch.trans_x <= point_on_bus.tx;
          in_ch.trans_y <= point_on_bus.ty;
          in_ch.trans_z <= point_on_bus.tz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver side and checking
  always @(posedge clk_i) begin
    pixel_item_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_expected.size() == 0) begin
          failures++;
          $display("%0t: unexpected item u=%h v=%h zero=%b sat=%b", $time,
                   out_ch.pixel_u, out_ch.pixel_v, out_ch.depth_zero, out_ch.saturated);
        end else begin
          want = pixels_expected.pop_front();
          if (out_ch.pixel_u !== want.u) begin
            failures++;
            $display("%0t: pixel_u expected %h actual %h", $time, want.u, out_ch.pixel_u);
          end
          if (out_ch.pixel_v !== want.v) begin
            failures++;
            $display("%0t: pixel_v expected %h actual %h", $time, want.v, out_ch.pixel_v);
          end
          if (out_ch.depth_zero !== want.zero_depth) begin
            failures++;
            $display("%0t: depth_zero expected %b actual %b", $time, want.zero_depth,
                     out_ch.depth_zero);
          end
          if (out_ch.saturated !== want.clipped) begin
            failures++;
            $display("%0t: saturated expected %b actual %b", $time, want.clipped,
                     out_ch.saturated);
          end
        end
      end
      out_ch.ready <= $urandom_range(99) >= receiver_stall_pct;
    end
  end

  // stops a hung run
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (points_pending.size() == 0 && pixels_expected.size() == 0 && !in_ch.valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned idle_set[4][2];
    idle_set = '{'{0, 0}, '{80, 0}, '{0, 80}, '{27, 27}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // edge points under reset settings
    points_pending.push_back(make_point(0, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
    points_pending.push_back(make_point(65536, -65536, 65536, 16384, 0, 0, 0, 0, 0, 0));
    points_pending.push_back(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                        16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    points_pending.push_back(make_point(32'h80000000, 32'h80000000, 32'h80000000,
                                        16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        32'h80000000, 32'h80000000, 32'h80000000));
    points_pending.push_back(make_point(32'h7fffffff, 32'h80000000, 1, 16384, 0, 0, 0,
                                        0, 0, 0));
    points_pending.push_back(make_point(65536, 65536, -65536, 16384, 0, 0, 0, 0, 0, 0));
    points_pending.push_back(make_point(1, 3, 2, 16384, 0, 0, 0, 0, 0, 0));
    points_pending.push_back(make_point(-1, -3, 2, 16384, 0, 0, 0, 0, 0, 0));
    points_pending.push_back(make_point(0, 0, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    points_pending.push_back(make_point(65536, 131072, 196608, 11585, 11585, 0, 0,
                                        0, 0, 655360));
    points_pending.push_back(make_point(655360, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
    points_pending.push_back(make_point(100, 200, 5 << 16, 0, 0, 0, 16384,
                                        -7, 9, 1 << 16));
    points_pending.push_back(make_point(32'h40000000, 0, 0, 16384, 0, 0, 0,
                                        0, 0, 32'hC0000000));
    points_pending.push_back(make_point(0, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                                        32'h7fffffff, 32'h80000000, 1));
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ;
        1: set_camera(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        2: set_camera(32'h0, 32'h7FFFFFFF, 32'h80000000);
        3: set_camera(32'd500 << 16, 32'd320 << 16, 32'd240 << 16);
        4: set_camera($urandom, $urandom, $urandom);
        default: begin
          set_camera($urandom_range(2000 << 16), $urandom, $urandom);
          write_reg(ADDR_UNMAPPED, $urandom);
        end
      endcase
      sender_idle_pct = idle_set[phase % 4][0];
      receiver_stall_pct = idle_set[phase % 4][1];
      for (int n = 0; n < RAND_PER_PHASE; n++)
        points_pending.push_back(rand_point());
      wait_drained();
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
